@@ rtl/core/urldec_pkg.sv @@
`timescale 1ns / 1ps

package urldec_pkg;

	// Character codes that the decoder treats specially.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Most result bytes that one encoded byte can cause.
	localparam int unsigned MAX_RES = 3;

	// Escape tracking: nothing held, '%' held, '%' and one hex digit held.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// Decoded bytes of one encoded byte, ready to be loaded into the output buffer.
	typedef struct packed {
		logic [1:0]                 count;
		logic [MAX_RES-1:0][7:0]    bytes;
		logic                       last;
	} dec_res_t;

	// Output buffer status seen by the control in the top level.
	typedef struct packed {
		logic can_load;
		logic busy;
	} buf_status_t;

	// True for 0-9, a-f and A-F.
	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
			(c >= 8'd65 && c <= 8'd70);
	endfunction

	// Nibble value of a hex digit; only meaningful when is_hex holds.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'd48 && c <= 8'd57) begin
			v = c - 8'd48;
		end else if (c >= 8'd97 && c <= 8'd102) begin
			v = c - 8'd87;
		end else begin
			v = c - 8'd55;
		end
		return v[3:0];
	endfunction

	// Decoded values that replace their escape: alphanumerics and a set of punctuation.
	function automatic logic is_allowed(input logic [7:0] v);
		logic ok;
		ok = (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
			(v >= 8'd65 && v <= 8'd90);
		case (v)
			8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
			8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
			8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F: ok = 1'b1;
			default: ;
		endcase
		return ok;
	endfunction

endpackage

@@ rtl/core/urldec_if.sv @@
`timescale 1ns / 1ps

// Encoded byte channel.
interface urldec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded byte channel.
interface urldec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       stream_end;

	modport source (output valid, output out_byte, output run_end, output stream_end,
		input ready);
	modport sink   (input valid, input out_byte, input run_end, input stream_end,
		output ready);
endinterface

@@ rtl/core/urldec_decode.sv @@
`timescale 1ns / 1ps

module urldec_decode (
	input  urldec_pkg::phase_t   phase,
	input  logic [7:0]           held,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output urldec_pkg::phase_t   nxt_phase,
	output logic [7:0]           nxt_held,
	output urldec_pkg::dec_res_t res
);
	import urldec_pkg::*;

	logic [7:0] esc_val;
	logic [1:0] n;
	logic       plain;

	// Value named by the held digit and the current digit.
	assign esc_val = {hex_val(held), hex_val(in_byte)};

	// Escape handling, then plain decoding, then the end-of-stream flush.
	always_comb begin
		n         = 2'd0;
		plain     = 1'b0;
		res.bytes = '0;
		nxt_phase = PH_IDLE;
		nxt_held  = held;

		case (phase)
			PH_PCT: begin
				if (is_hex(in_byte)) begin
					nxt_held  = in_byte;
					nxt_phase = PH_DIGIT;
				end else begin
					res.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
					plain = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (is_hex(in_byte)) begin
					if (is_allowed(esc_val)) begin
						res.bytes[n] = esc_val;
						n = n + 2'd1;
					end else begin
						res.bytes[0] = CH_PERCENT;
						res.bytes[1] = held;
						res.bytes[2] = in_byte;
						n = 2'd3;
					end
				end else begin
					res.bytes[0] = CH_PERCENT;
					res.bytes[1] = held;
					n = 2'd2;
					plain = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase

		// A byte seen with no escape open.
		if (plain) begin
			if (in_byte == CH_PERCENT) begin
				nxt_phase = PH_PCT;
			end else begin
				res.bytes[n] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
				n = n + 2'd1;
			end
		end

		// At the end of the stream whatever is still held goes out raw.
		if (in_last) begin
			if (nxt_phase == PH_PCT) begin
				res.bytes[n] = CH_PERCENT;
				n = n + 2'd1;
			end else if (nxt_phase == PH_DIGIT) begin
				res.bytes[n] = CH_PERCENT;
				n = n + 2'd1;
				res.bytes[n] = nxt_held;
				n = n + 2'd1;
			end
			nxt_phase = PH_IDLE;
			nxt_held  = 8'd0;
		end

		res.count = n;
		res.last  = in_last;
	end

endmodule

@@ rtl/core/urldec_outbuf.sv @@
`timescale 1ns / 1ps

module urldec_outbuf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  urldec_pkg::dec_res_t      res,
	output urldec_pkg::buf_status_t   status,
	urldec_out_if.source              dec
);
	import urldec_pkg::*;

	logic [MAX_RES-1:0][7:0] bytes_q;
	logic [1:0]              cnt_q;
	logic [1:0]              rd_q;
	logic                    last_q;
	logic                    xfer;

	// Present the next waiting byte; the final one closes the run.
	assign dec.valid      = (cnt_q != 2'd0);
	assign dec.out_byte   = bytes_q[rd_q];
	assign dec.run_end    = (cnt_q == 2'd1);
	assign dec.stream_end = (cnt_q == 2'd1) && last_q;
	assign xfer           = dec.valid && dec.ready;

	// A new run may enter once the current one is gone or leaves in this cycle.
	assign status.can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && dec.ready);
	assign status.busy     = dec.valid;

	// Run bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			rd_q   <= 2'd0;
			last_q <= 1'b0;
		end else if (load && (res.count != 2'd0)) begin
			cnt_q  <= res.count;
			rd_q   <= 2'd0;
			last_q <= res.last;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// Byte storage of the run.
	always_ff @(posedge clk) begin
		if (load && (res.count != 2'd0)) begin
			bytes_q <= res.bytes;
		end
	end

endmodule

@@ rtl/core/url_percent_decoder.sv @@
`timescale 1ns / 1ps
// A byte accepted into the input register is decoded combinationally from it and loaded
// into the output buffer once that can take it; its first result is offered from there.
// Throughput: one encoded byte per cycle while each byte yields at most one result and
// the receiver is ready; a byte with several results holds the output buffer until all leave.
// Reset (arst_n low) empties the input and output registers and closes any escape.
module url_percent_decoder (
	input logic          clk,
	input logic          arst_n,
	urldec_in_if.sink    enc,
	urldec_out_if.source dec
);
	import urldec_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	phase_t      phase_q;
	logic [7:0]  held_q;
	phase_t      nxt_phase;
	logic [7:0]  nxt_held;
	dec_res_t    res;
	buf_status_t buf_st;
	logic        load;

	// The registered byte is decoded once the output buffer can take its results.
	assign load      = v_s1 && buf_st.can_load;
	assign enc.ready = !v_s1 || load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (enc.valid && enc.ready) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc.valid && enc.ready) begin
			byte_s1 <= enc.in_byte;
			last_s1 <= enc.in_last;
		end
	end

	// Escape state advances with each decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (load) begin
			phase_q <= nxt_phase;
			held_q  <= nxt_held;
		end
	end

	urldec_decode u_decode (
		.phase     (phase_q),
		.held      (held_q),
		.in_byte   (byte_s1),
		.in_last   (last_s1),
		.nxt_phase (nxt_phase),
		.nxt_held  (nxt_held),
		.res       (res)
	);

	urldec_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (res),
		.status (buf_st),
		.dec    (dec)
	);

	// The last byte of a stream always produces at least one result.
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_s1 |-> res.count != 2'd0)
		else $error("end of stream decoded with no result");

	// After the last byte no escape stays open.
	a_last_closes_escape: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_s1 |=> phase_q == PH_IDLE)
		else $error("escape still open after end of stream");

	// A new run never overwrites bytes that have not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load && res.count != 2'd0 |-> !buf_st.busy || (dec.ready && dec.run_end))
		else $error("output run overwritten before transfer");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

import urldec_pkg::*;

// One expected decoded byte with its framing flags.
typedef struct packed {
	logic [7:0] data;
	logic       run_end;
	logic       stream_end;
} decoded_want_t;

// Tracks the escape state of the encoded stream, predicts the decoded bytes of each
// accepted transfer and checks the decoded transfers against them in order.
class decoded_byte_board;
	phase_t          escape_state;
	logic [7:0]      held_hex;
	logic [7:0]      run_bytes [4];
	int              run_len;
	decoded_want_t   want_bytes [$];
	int              errors;
	int              encoded_seen;
	int              decoded_seen;
	int              escapes_replaced;
	int              escapes_kept;
	int              streams_closed;

	function new();
		escape_state = PH_IDLE;
		held_hex = 8'h00;
		errors = 0;
		encoded_seen = 0;
		decoded_seen = 0;
		escapes_replaced = 0;
		escapes_kept = 0;
		streams_closed = 0;
	endfunction

	function bit hex_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// Value of a hex digit; folding to lower case covers both letter forms.
	function logic [3:0] nibble(input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] d;
		lc = c | 8'h20;
		if (c <= "9")
			d = c - "0";
		else
			d = lc - "a" + 8'd10;
		return d[3:0];
	endfunction

	// Decoded values that are allowed to replace their escape.
	function bit keeps_decoding(input logic [7:0] v);
		if ((v >= "0" && v <= "9") || (v >= "a" && v <= "z") || (v >= "A" && v <= "Z"))
			return 1'b1;
		case (v)
			"!", "$", "&", "'", "(", ")", "*", "+", ",", "-", ".", "/",
			":", ";", "=", "?", "@", "_": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function void push_byte(input logic [7:0] b);
		run_bytes[run_len] = b;
		run_len++;
	endfunction

	// A byte seen with no escape open.
	function void decode_plain(input logic [7:0] b);
		if (b == CH_PERCENT) begin
			escape_state = PH_PCT;
		end else if (b == CH_PLUS) begin
			push_byte(CH_SPACE);
		end else begin
			push_byte(b);
		end
	endfunction

	// Work out the decoded bytes that one accepted encoded transfer causes.
	function void note_encoded(input logic [7:0] b, input logic last);
		logic [7:0] v;
		decoded_want_t w;
		run_len = 0;
		encoded_seen++;
		case (escape_state)
			PH_PCT: begin
				if (hex_char(b)) begin
					held_hex = b;
					escape_state = PH_DIGIT;
				end else begin
					push_byte(CH_PERCENT);
					escape_state = PH_IDLE;
					decode_plain(b);
				end
			end
			PH_DIGIT: begin
				if (hex_char(b)) begin
					v = {nibble(held_hex), nibble(b)};
					if (keeps_decoding(v)) begin
						push_byte(v);
						escapes_replaced++;
					end else begin
						push_byte(CH_PERCENT);
						push_byte(held_hex);
						push_byte(b);
						escapes_kept++;
					end
					escape_state = PH_IDLE;
				end else begin
					push_byte(CH_PERCENT);
					push_byte(held_hex);
					escape_state = PH_IDLE;
					decode_plain(b);
				end
			end
			default: begin
				escape_state = PH_IDLE;
				decode_plain(b);
			end
		endcase

		// End of stream flushes whatever part of an escape is still open.
		if (last) begin
			if (escape_state == PH_PCT) begin
				push_byte(CH_PERCENT);
			end else if (escape_state == PH_DIGIT) begin
				push_byte(CH_PERCENT);
				push_byte(held_hex);
			end
			escape_state = PH_IDLE;
			held_hex = 8'h00;
			streams_closed++;
		end

		for (int k = 0; k < run_len; k++) begin
			w.data = run_bytes[k];
			w.run_end = (k == run_len - 1);
			w.stream_end = (k == run_len - 1) && last;
			want_bytes.insert(want_bytes.size(), w);
		end
	endfunction

	// Compare one decoded transfer with the oldest expected byte.
	function void check_decoded(input logic [7:0] b, input logic re, input logic se);
		decoded_want_t w;
		decoded_seen++;
		if (want_bytes.size() == 0) begin
			errors++;
			$display("%0t: decoded byte %h run_end %b stream_end %b, expected nothing",
				$time, b, re, se);
			return;
		end
		w = want_bytes.pop_front();
		if (w.data !== b || w.run_end !== re || w.stream_end !== se) begin
			errors++;
			$display("%0t: expected byte %h run_end %b stream_end %b, got %h %b %b",
				$time, w.data, w.run_end, w.stream_end, b, re, se);
		end
	endfunction

	function int pending();
		return want_bytes.size();
	endfunction
endclass

module tb;
	localparam int RANDOM_ITEMS = 135;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycle_count = 0;
	int   burst_left = 0;
	int   stall_mode = 0;
	int   stall_left = 0;
	int   stall_tick = 0;

	urldec_in_if  enc_ch ();
	urldec_out_if dec_ch ();

	decoded_byte_board board;

	url_percent_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_ch.sink),
		.dec    (dec_ch.source)
	);

	always #5 clk = ~clk;

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("url_percent_decoder: mismatch");
			$finish;
		end
	end

	// Receiver back-pressure: stretches of always-ready alternate with stall patterns.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 40);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			0: dec_ch.ready <= 1'b1;
			1: dec_ch.ready <= 1'($urandom_range(0, 1));
			2: dec_ch.ready <= ($urandom_range(0, 3) == 0);
			default: dec_ch.ready <= (stall_tick % 3 != 0);
		endcase
	end

	// Check every decoded transfer.
	always @(posedge clk) begin
		if (arst_n && dec_ch.valid && dec_ch.ready)
			board.check_decoded(dec_ch.out_byte, dec_ch.run_end, dec_ch.stream_end);
	end

	// Offer one encoded byte, with an occasional gap between bursts, and wait for the
	// transfer. Called and returns at a falling edge.
	task automatic send_encoded(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				enc_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		enc_ch.valid <= 1'b1;
		enc_ch.in_byte <= b;
		enc_ch.in_last <= last;
		@(posedge clk);
		while (!enc_ch.ready)
			@(posedge clk);
		board.note_encoded(b, last);
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_digit_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return "0" + n;
		return (upper ? "A" : "a") + n - 8'd10;
	endfunction

	function automatic logic [7:0] random_hex_digit();
		return hex_digit_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endfunction

	function automatic logic [7:0] random_non_hex();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (board.hex_char(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// Stimulus and end of run.
	initial begin
		int sent;
		int pick;
		logic [7:0] v;
		board = new();
		enc_ch.valid = 1'b0;
		enc_ch.in_byte = 8'h00;
		enc_ch.in_last = 1'b0;
		dec_ch.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: plus, allowed and refused escapes, broken escapes, high bytes, flushes.
		send_encoded(CH_PLUS, 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("4", 1'b0);
		send_encoded("1", 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("2", 1'b0);
		send_encoded("b", 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("2", 1'b0);
		send_encoded("0", 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("4", 1'b0);
		send_encoded("g", 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("6", 1'b0);
		send_encoded("A", 1'b0);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded(CH_PLUS, 1'b0);
		send_encoded(8'hFF, 1'b0);
		send_encoded(8'h00, 1'b0);
		send_encoded(8'h80, 1'b1);
		send_encoded(CH_PERCENT, 1'b1);
		send_encoded(CH_PERCENT, 1'b0);
		send_encoded("F", 1'b1);

		// Random: mostly complete escapes with random digits, plus noise and broken ones.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_encoded(CH_PERCENT, ($urandom_range(0, 19) == 0));
				send_encoded(random_hex_digit(), ($urandom_range(0, 19) == 0));
				send_encoded(random_hex_digit(), ($urandom_range(0, 9) == 0));
				sent += 3;
			end else if (pick < 55) begin
				send_encoded(CH_PERCENT, 1'b0);
				if ($urandom_range(0, 1) == 1) begin
					send_encoded(random_hex_digit(), 1'b0);
					sent++;
				end
				v = ($urandom_range(0, 3) == 0) ? CH_PERCENT : random_non_hex();
				send_encoded(v, ($urandom_range(0, 9) == 0));
				sent += 2;
			end else if (pick < 65) begin
				send_encoded(CH_PLUS, ($urandom_range(0, 19) == 0));
				sent++;
			end else begin
				send_encoded(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
				sent++;
			end
		end
		send_encoded("z", 1'b1);

		// Drain, then allow the pipeline to settle.
		enc_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d encoded bytes over %0d streams; checked %0d decoded bytes.",
			board.encoded_seen, board.streams_closed, board.decoded_seen);
		$display("Escapes replaced: %0d, escapes passed through raw: %0d.",
			board.escapes_replaced, board.escapes_kept);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("url_percent_decoder: match");
		end else begin
			$display("url_percent_decoder: mismatch");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/urldec_pkg.sv
rtl/core/urldec_if.sv
rtl/core/urldec_decode.sv
rtl/core/urldec_outbuf.sv
rtl/core/url_percent_decoder.sv
tb/tb.sv
